// ===== rtl/lrip_pkg.sv =====
// Shared types and constants for the LRU insertion replacement core.
package lrip_pkg;

  localparam int STAMP_W = 32;
  localparam int SET_W   = 6;
  localparam int WAY_W   = 4;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;
    logic load;
    logic hit_wr;
    logic scan;
    logic miss_wr;
    logic emit;
  } lrip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic in_victim;
    logic set_ok;
    logic way_ok;
    logic in_hit;
    logic item_victim;
    logic scan_last;
    logic out_free;
  } lrip_stat_t;

endpackage

// ===== rtl/lrip_dp.sv =====
// Datapath: stamp memory, clearing counter, minimum scan and result register.
module lrip_dp
  import lrip_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lrip_cmd_t            cmd,
  output lrip_stat_t           stat,
  input  logic                 operation,
  input  logic [SET_W-1:0]     set_index,
  input  logic [WAY_W-1:0]     way_index,
  input  logic                 was_hit,
  input  logic [STAMP_W-1:0]   cycle_now,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WAY_W-1:0]     victim_way
);

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [31:0] SETS_LIM = 32'(SETS);
  localparam logic [31:0] WAYS_LIM = 32'(WAYS);

  typedef logic [WAYS-1:0][STAMP_W-1:0] row_t;

  row_t mem [SETS];
  row_t row;

  logic [SW-1:0]      clr_addr;
  logic [SW-1:0]      in_set;
  logic [WW-1:0]      in_way;
  logic [SW-1:0]      item_set;
  logic [WW-1:0]      item_way;
  logic               item_op;
  logic [WW-1:0]      k;
  logic [WW-1:0]      best;
  logic [STAMP_W-1:0] best_val;
  logic [STAMP_W-1:0] miss_val;

  assign in_set   = SW'(set_index);
  assign in_way   = WW'(way_index);
  assign miss_val = (best_val == '0) ? '0 : best_val - STAMP_W'(1);

  assign stat.clr_last    = (clr_addr == SW'(SETS - 1));
  assign stat.in_victim   = (operation == OP_VICTIM);
  assign stat.set_ok      = ({{(32 - SET_W){1'b0}}, set_index} < SETS_LIM);
  assign stat.way_ok      = ({{(32 - WAY_W){1'b0}}, way_index} < WAYS_LIM);
  assign stat.in_hit      = was_hit;
  assign stat.item_victim = (item_op == OP_VICTIM);
  assign stat.scan_last   = (k == WW'(WAYS - 1));
  assign stat.out_free    = !out_valid || out_ready;

  // Stamp memory: one row per set. A clear zeroes a whole row; updates write one way at a time.
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_addr] <= '0;
    end else if (cmd.hit_wr) begin
      mem[in_set][in_way] <= cycle_now;
    end else if (cmd.miss_wr) begin
      mem[item_set][item_way] <= miss_val;
    end
    if (cmd.load) begin
      row <= mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + SW'(1);
    end
  end

  // Item registers and the running minimum over the ways of the row.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_set <= in_set;
      item_way <= in_way;
      item_op  <= operation;
      k        <= '0;
      best     <= '0;
      best_val <= '1;
    end else if (cmd.scan) begin
      k <= k + WW'(1);
      if (row[k] < best_val) begin
        best     <= k;
        best_val <= row[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      victim_way <= WAY_W'(best);
    end
  end

endmodule

// ===== rtl/lrip_ctrl.sv =====
// Controller state machine that sequences clearing, scans, writes and results.
module lrip_ctrl
  import lrip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lrip_stat_t stat,
  output lrip_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_WRITE = 6'b001000,
    S_EMIT  = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (stat.in_victim) begin
            state_next = stat.set_ok ? S_SCAN : S_EMIT;
          end else if (stat.set_ok && stat.way_ok) begin
            if (stat.in_hit) begin
              cmd.hit_wr = 1'b1;
            end else begin
              state_next = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) state_next = stat.item_victim ? S_EMIT : S_WRITE;
      end
      S_WRITE: begin
        cmd.miss_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/lru_insertion_replacement_core.sv =====
// Top level of the LRU insertion replacement core: controller plus datapath.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+--------------------------------------------------
//   input   | in_valid / in_ready  | operation, set_index, way_index, was_hit, cycle_now
//   output  | out_valid / out_ready| victim_way
//
// A hit update is written into the stamp memory in the cycle of its transfer. A
// victim request or a miss update reads the set's row, then scans one way per cycle
// for the smallest stamp with the single compare unit in the scan loop.
// After reset a clearing pass zeroes the memory one set per cycle while in_ready
// stays low. A victim result waits in its own output register, so the next item
// is taken while the result is still pending; only a second result stalls behind
// an untaken one. Updates for an out-of-range set or way are dropped.
module lru_insertion_replacement_core
  import lrip_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [SET_W-1:0]   set_index,
  input  logic [WAY_W-1:0]   way_index,
  input  logic               was_hit,
  input  logic [STAMP_W-1:0] cycle_now,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WAY_W-1:0]   victim_way
);

  lrip_cmd_t  cmd;
  lrip_stat_t stat;

  // The controller decides on each transfer from status that the datapath
  // derives from the presented payload and from the latched item.
  lrip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrip_dp #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .operation  (operation),
    .set_index  (set_index),
    .way_index  (way_index),
    .was_hit    (was_hit),
    .cycle_now  (cycle_now),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .victim_way (victim_way)
  );

endmodule

// ===== tb/sv/tb_lru_insertion_replacement_core.sv =====
// Self-checking testbench for the LRU insertion replacement core.
module tb_lru_insertion_replacement_core;
  import lrip_pkg::*;

  localparam int SETS        = 64;
  localparam int WAYS        = 16;
  localparam int ITEM_GOAL   = 1550;
  localparam int HOLD_CYCLES = 400;
  // The slowest legal run is roughly 1550 scans, plus sender gaps, a slow receiver and
  // the clearing pass. This limit leaves several times that margin.
  localparam int CYCLE_LIMIT = 800000;

  // Receiver behaviors. Each one lasts for a random number of cycles.
  typedef enum int {RX_READY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               operation;
  logic [SET_W-1:0]   set_index;
  logic [WAY_W-1:0]   way_index;
  logic               was_hit;
  logic [STAMP_W-1:0] cycle_now;
  logic               out_valid;
  logic               out_ready;
  logic [WAY_W-1:0]   victim_way;

  // This is the testbench's own copy of the last-use stamps. Each input is applied to it
  // when its transfer is accepted.
  logic [STAMP_W-1:0] stamp_mirror [SETS][WAYS];
  // Victim ways that are predicted but not yet seen, oldest first.
  logic [WAY_W-1:0]   victim_expect_q [$];

  int  fail_count = 0;
  int  items_sent = 0;
  int  victims_sent = 0;
  int  hits_sent = 0;
  int  misses_sent = 0;
  int  results_checked = 0;
  int  input_stall_cycles = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  int  hold_off_seq = 0;
  bit  gaps_enabled = 1'b1;

  lru_insertion_replacement_core #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .set_index (set_index),
    .way_index (way_index),
    .was_hit   (was_hit),
    .cycle_now (cycle_now),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .victim_way(victim_way)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The victim is the way with the smallest stamp. A strict compare keeps the lowest
  // index when stamps are tied. A 6-bit set index always falls inside the 64 sets.
  function automatic logic [WAY_W-1:0] oldest_way(input logic [SET_W-1:0] s);
    logic [WAY_W-1:0] best;
    best = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (stamp_mirror[s][w] < stamp_mirror[s][best]) best = WAY_W'(w);
    end
    return best;
  endfunction

  // A hit takes the current cycle. A miss takes one below the oldest stamp in the set,
  // and this count includes the target way's own old value. It stops at zero and does
  // not wrap.
  function automatic void record_update(input logic [SET_W-1:0] s, input logic [WAY_W-1:0] w,
                                        input logic hit, input logic [STAMP_W-1:0] now);
    logic [STAMP_W-1:0] low;
    if (hit) begin
      stamp_mirror[s][w] = now;
    end else begin
      low = stamp_mirror[s][oldest_way(s)];
      stamp_mirror[s][w] = (low == '0) ? '0 : low - STAMP_W'(1);
    end
  endfunction

  // This task offers one access and returns at the edge where it is transferred. Between
  // bursts, valid drops for a random gap. Within a burst, valid stays high from one item
  // to the next.
  task automatic send_access(input logic op, input logic [SET_W-1:0] s,
                             input logic [WAY_W-1:0] w, input logic hit,
                             input logic [STAMP_W-1:0] now);
    int gap;
    if (gaps_enabled && burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid  <= 1'b1;
    operation <= op;
    set_index <= s;
    way_index <= w;
    was_hit   <= hit;
    cycle_now <= now;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op == OP_VICTIM) begin
      victim_expect_q.insert(victim_expect_q.size(), oldest_way(s));
      victims_sent++;
    end else begin
      record_update(s, w, hit, now);
      if (hit) hits_sent++;
      else misses_sent++;
    end
  endtask

  // After reset every stamp is zero, so each set reports way 0.
  task automatic test_reset_state();
    send_access(OP_VICTIM, '0, '1, 1'b1, '1);
    send_access(OP_VICTIM, '1, '0, 1'b0, '0);
  endtask

  // This test covers tie breaking and a miss that meets a zero stamp.
  task automatic test_tie_and_zero_hold();
    send_access(OP_UPDATE, 6'd0, 4'd0, 1'b1, 32'hFFFF_FFFF);
    send_access(OP_VICTIM, 6'd0, 4'd0, 1'b0, '0);
    send_access(OP_UPDATE, 6'd0, 4'd1, 1'b0, 32'h1234_5678);
    send_access(OP_VICTIM, 6'd0, 4'd9, 1'b1, '0);
  endtask

  // This test fills every way of one set, so that the oldest stamp is not zero. A miss
  // then lands just below that stamp and takes the oldest place.
  task automatic test_full_set_order();
    for (int w = 0; w < WAYS; w++)
      send_access(OP_UPDATE, 6'd42, WAY_W'(w), 1'b1, 32'h5555_0000 + STAMP_W'(WAYS - 1 - w));
    send_access(OP_VICTIM, 6'd42, 4'd0, 1'b0, '0);
    send_access(OP_UPDATE, 6'd42, 4'd7, 1'b0, 32'hAAAA_AAAA);
    send_access(OP_VICTIM, 6'd42, 4'd0, 1'b0, '0);
  endtask

  // In this test the receiver holds off for a long stretch while victim requests arrive
  // one after another. The output register fills and the core then stalls its input.
  task automatic test_output_backpressure();
    bit saved_gaps;
    saved_gaps = gaps_enabled;
    gaps_enabled = 1'b0;
    hold_off_seq++;
    for (int i = 0; i < 12; i++)
      send_access(OP_VICTIM, SET_W'(i * 5 + 2), WAY_W'(i), 1'(i), $urandom());
    send_access(OP_UPDATE, 6'd42, 4'd15, 1'b1, $urandom());
    send_access(OP_VICTIM, 6'd42, 4'd0, 1'b0, '0);
    gaps_enabled = saved_gaps;
  endtask

  // Most random traffic runs on a few hot sets. Half the time a set is first filled
  // in shuffled way order. It then gets a mix of victim lookups, fills into the chosen
  // victim, hits, stamps copied from other ways to force ties, and stray misses. The
  // rest is noise across every set and field value.
  task automatic test_random_traffic(input int item_goal);
    logic [SET_W-1:0]   hot_sets [4];
    logic [SET_W-1:0]   s;
    logic [WAY_W-1:0]   w;
    logic [STAMP_W-1:0] clock_now;
    logic [STAMP_W-1:0] noisy;
    int                 fill_order [WAYS];
    int                 stop_at;
    int                 pick;
    int                 run_len;
    int                 j;
    int                 tmp;
    stop_at = items_sent + item_goal;
    clock_now = $urandom();
    foreach (hot_sets[i]) hot_sets[i] = SET_W'($urandom_range(0, SETS - 1));
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0)
        hot_sets[$urandom_range(0, 3)] = SET_W'($urandom_range(0, SETS - 1));
      s = hot_sets[$urandom_range(0, 3)];
      if ($urandom_range(0, 1) == 1) begin
        foreach (fill_order[i]) fill_order[i] = i;
        for (int i = WAYS - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = fill_order[i];
          fill_order[i] = fill_order[j];
          fill_order[j] = tmp;
        end
        foreach (fill_order[i]) begin
          clock_now += $urandom_range(1, 64);
          send_access(OP_UPDATE, s, WAY_W'(fill_order[i]), 1'b1, clock_now);
        end
      end
      run_len = $urandom_range(10, 40);
      for (int n = 0; n < run_len && items_sent < stop_at; n++) begin
        pick = $urandom_range(0, 99);
        clock_now += $urandom_range(1, 64);
        w = WAY_W'($urandom_range(0, WAYS - 1));
        if (pick < 30) begin
          send_access(OP_VICTIM, s, w, 1'($urandom_range(0, 1)), $urandom());
        end else if (pick < 50) begin
          // This is a normal miss: ask for the victim, then fill that way.
          w = oldest_way(s);
          send_access(OP_VICTIM, s, WAY_W'($urandom_range(0, WAYS - 1)), 1'b0, '0);
          send_access(OP_UPDATE, s, w, 1'b0, $urandom());
        end else if (pick < 80) begin
          send_access(OP_UPDATE, s, w, 1'b1, clock_now);
        end else if (pick < 88) begin
          send_access(OP_UPDATE, s, w, 1'b1, stamp_mirror[s][$urandom_range(0, WAYS - 1)]);
        end else if (pick < 93) begin
          send_access(OP_UPDATE, s, w, 1'b0, $urandom());
        end else begin
          case ($urandom_range(0, 2))
            0:       noisy = '0;
            1:       noisy = '1;
            default: noisy = $urandom();
          endcase
          send_access(1'($urandom_range(0, 1)), SET_W'($urandom_range(0, SETS - 1)), w,
                      1'($urandom_range(0, 1)), noisy);
        end
      end
    end
  endtask

  // The receiver picks a new behavior at the end of each random segment. When the test
  // asks for a hold-off, the receiver counts that long stretch down here.
  initial begin : receiver
    rx_mode_t mode;
    int       seg_left;
    int       hold_left;
    int       hold_seen;
    int       tick;
    mode = RX_READY;
    seg_left = 0;
    hold_left = 0;
    hold_seen = 0;
    tick = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_off_seq != hold_seen) begin
        hold_seen = hold_off_seq;
        hold_left = HOLD_CYCLES;
      end
      if (seg_left <= 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(5, 60);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_READY:  out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 5) == 0);
          default:   out_ready <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  // Each victim_way transfer is compared with the oldest prediction.
  always @(posedge clk) begin : victim_check
    logic [WAY_W-1:0] want_way;
    if (!rst && out_valid && out_ready) begin
      if (victim_expect_q.size() == 0) begin
        $error("victim_way: transfer with no result expected, actual %0d", victim_way);
        fail_count++;
      end else begin
        want_way = victim_expect_q.pop_front();
        results_checked++;
        if (victim_way !== want_way) begin
          $error("victim_way mismatch: expected %0d, actual %0d", want_way, victim_way);
          fail_count++;
        end
      end
    end
  end

  // This block counts cycles with input stalled, for the summary, and ends a run that
  // hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && in_valid && !in_ready) input_stall_cycles <= input_stall_cycles + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, victim_expect_q.size());
      $display("** lru_insertion_replacement_core: FAILED **");
      $finish;
    end
  end

  initial begin : run
    // Every stamp starts at zero, as in the core after its clearing pass.
    foreach (stamp_mirror[i, j]) stamp_mirror[i][j] = '0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = OP_VICTIM;
    set_index = '0;
    way_index = '0;
    was_hit   = 1'b0;
    cycle_now = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // The first transfer waits for the clearing pass, because in_ready stays low
    // until that pass ends.
    test_reset_state();
    test_tie_and_zero_hold();
    test_full_set_order();
    test_output_backpressure();
    test_random_traffic(ITEM_GOAL - items_sent);
    in_valid <= 1'b0;
    while (victim_expect_q.size() != 0) @(posedge clk);
    // Stay on long enough for a full scan, so that a late extra result is caught.
    repeat (4 * WAYS) @(posedge clk);
    $display("Covered %0d accesses: %0d victim lookups, %0d hit and %0d miss updates.",
             items_sent, victims_sent, hits_sent, misses_sent);
    $display("Compared %0d victim results; input was held off for %0d cycles in all.",
             results_checked, input_stall_cycles);
    if (fail_count == 0) begin
      $display("** lru_insertion_replacement_core: PASSED **");
    end else begin
      $display("** lru_insertion_replacement_core: FAILED **");
    end
    $finish;
  end

endmodule
